// File: src/kst_pkg.sv
// shared types, constants and key tables of the scan code translator
package kst_pkg;

    localparam int CMD_QUEUE_DEPTH = 32;
    localparam int QIDX_W = $clog2(CMD_QUEUE_DEPTH);
    localparam int QCNT_W = $clog2(CMD_QUEUE_DEPTH + 1);

    localparam logic [7:0] LED_CMD         = 8'hED;
    localparam logic [7:0] SC_LSHIFT_MAKE  = 8'h2A;
    localparam logic [7:0] SC_RSHIFT_MAKE  = 8'h36;
    localparam logic [7:0] SC_LSHIFT_BREAK = 8'hAA;
    localparam logic [7:0] SC_RSHIFT_BREAK = 8'hB6;
    localparam logic [7:0] SC_CAPS         = 8'h3A;
    localparam logic [7:0] SC_NUM          = 8'h45;
    localparam logic [7:0] SC_SCROLL       = 8'h46;
    localparam logic [7:0] SC_ACK          = 8'hFA;
    localparam logic [7:0] SC_RESEND       = 8'hFE;
    localparam logic [7:0] SC_TAB          = 8'h0F;
    localparam logic [7:0] CASE_OFFSET     = 8'h20;
    localparam logic [7:0] CHAR_UPPER_A    = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z    = 8'h5A;

    localparam logic [2:0] LED_CAPS   = 3'b100;
    localparam logic [2:0] LED_NUM    = 3'b010;
    localparam logic [2:0] LED_SCROLL = 3'b001;

    typedef enum logic [1:0] {
        CMD_SCAN = 2'd0,
        CMD_POLL = 2'd1,
        CMD_SYNC = 2'd2
    } command_t;

    typedef enum logic [1:0] {
        KIND_CHAR  = 2'd0,
        KIND_SEND  = 2'd1,
        KIND_FOCUS = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        SRC_DIRECT  = 2'd0,
        SRC_RAM     = 2'd1,
        SRC_PENDING = 2'd2
    } value_src_t;

    typedef struct packed {
        logic       valid;
        kind_t      kind;
        value_src_t src;
        logic [7:0] value;
    } result_t;

    function automatic logic [7:0] key_char(input logic [6:0] idx, input logic shifted);
        logic [7:0] ch;
        begin
            ch = 8'h00;
            case (idx)
                7'h02: ch = shifted ? 8'h21 : 8'h31;
                7'h03: ch = shifted ? 8'h40 : 8'h32;
                7'h04: ch = shifted ? 8'h23 : 8'h33;
                7'h05: ch = shifted ? 8'h24 : 8'h34;
                7'h06: ch = shifted ? 8'h25 : 8'h35;
                7'h07: ch = shifted ? 8'h5E : 8'h36;
                7'h08: ch = shifted ? 8'h26 : 8'h37;
                7'h09: ch = shifted ? 8'h2A : 8'h38;
                7'h0A: ch = shifted ? 8'h28 : 8'h39;
                7'h0B: ch = shifted ? 8'h29 : 8'h30;
                7'h0C: ch = shifted ? 8'h5F : 8'h2D;
                7'h0D: ch = shifted ? 8'h2B : 8'h3D;
                7'h0E: ch = 8'h08;
                7'h10: ch = 8'h51;
                7'h11: ch = 8'h57;
                7'h12: ch = 8'h45;
                7'h13: ch = 8'h52;
                7'h14: ch = 8'h54;
                7'h15: ch = 8'h59;
                7'h16: ch = 8'h55;
                7'h17: ch = 8'h49;
                7'h18: ch = 8'h4F;
                7'h19: ch = 8'h50;
                7'h1A: ch = shifted ? 8'h7B : 8'h5B;
                7'h1B: ch = shifted ? 8'h7D : 8'h5D;
                7'h1C: ch = 8'h0A;
                7'h1E: ch = 8'h41;
                7'h1F: ch = 8'h53;
                7'h20: ch = 8'h44;
                7'h21: ch = 8'h46;
                7'h22: ch = 8'h47;
                7'h23: ch = 8'h48;
                7'h24: ch = 8'h4A;
                7'h25: ch = 8'h4B;
                7'h26: ch = 8'h4C;
                7'h27: ch = shifted ? 8'h3A : 8'h3B;
                7'h28: ch = shifted ? 8'h22 : 8'h27;
                7'h29: ch = shifted ? 8'h7E : 8'h60;
                7'h2B: ch = shifted ? 8'h7C : 8'h5C;
                7'h2C: ch = 8'h5A;
                7'h2D: ch = 8'h58;
                7'h2E: ch = 8'h43;
                7'h2F: ch = 8'h56;
                7'h30: ch = 8'h42;
                7'h31: ch = 8'h4E;
                7'h32: ch = 8'h4D;
                7'h33: ch = shifted ? 8'h3C : 8'h2C;
                7'h34: ch = shifted ? 8'h3E : 8'h2E;
                7'h35: ch = shifted ? 8'h3F : 8'h2F;
                7'h37: ch = 8'h2A;
                7'h39: ch = 8'h20;
                7'h47: ch = 8'h37;
                7'h48: ch = 8'h38;
                7'h49: ch = 8'h39;
                7'h4A: ch = 8'h2D;
                7'h4B: ch = 8'h34;
                7'h4C: ch = 8'h35;
                7'h4D: ch = 8'h36;
                7'h4E: ch = 8'h2B;
                7'h4F: ch = 8'h31;
                7'h50: ch = 8'h32;
                7'h51: ch = 8'h33;
                7'h52: ch = 8'h30;
                7'h53: ch = 8'h2E;
                7'h73: ch = shifted ? 8'h5F : 8'h5C;
                7'h7D: ch = shifted ? 8'h7C : 8'h5C;
                default: ch = 8'h00;
            endcase
            return ch;
        end
    endfunction

endpackage

// File: src/kst_ram.sv
// generic single-write, single-read RAM with registered read data
module kst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: src/kst_keymap.sv
// scan code to character lookup with shift and caps lock case folding
module kst_keymap
    import kst_pkg::*;
(
    input  logic [7:0] code,
    input  logic       shifted,
    input  logic       caps,
    output logic [7:0] ch
);

    logic [7:0] raw;
    logic       is_letter;

    always_comb
    begin
        raw       = code[7] ? 8'h00 : key_char(code[6:0], shifted);
        is_letter = (raw >= CHAR_UPPER_A) && (raw <= CHAR_UPPER_Z);
        ch        = (is_letter && (caps == shifted)) ? (raw + CASE_OFFSET) : raw;
    end

endmodule

// File: src/keyboard_scancode_translator.sv
// top level of the set-1 scan code translator
//
// channel   direction  tdata          tuser        tlast
// s_axis    in         scancode[7:0]  command[1:0] -
// m_axis    out        value[7:0]     kind[1:0]    last
// cfg       in         initial_leds   -            -
//
// a word is taken into an input register and finished by the logic behind it, so a new word is
// accepted every cycle unless the result stalls; lock keys and led sync take a second pass, one
// per byte written into the single write port of the command queue memory.
// the result register is refilled in the cycle it is taken; a stall there holds the input.
// reset clears all control state; the queue memory needs no clearing pass.
module keyboard_scancode_translator
    import kst_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // scancode[7:0]
    input  logic [1:0] s_axis_tuser,   // command[1:0]
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // value[7:0]
    output logic [1:0] m_axis_tuser,   // kind[1:0]
    output logic       m_axis_tlast,
    input  logic       cfg_wr_en,
    input  logic [2:0] cfg_wr_data
);

    localparam logic [QIDX_W:0]   DEPTH_SUM = (QIDX_W + 1)'(CMD_QUEUE_DEPTH);
    localparam logic [QCNT_W-1:0] DEPTH_CNT = QCNT_W'(CMD_QUEUE_DEPTH);
    localparam logic [QIDX_W-1:0] LAST_IDX  = QIDX_W'(CMD_QUEUE_DEPTH - 1);

    logic              in_valid_reg;
    command_t          in_cmd_reg;
    logic [7:0]        in_code_reg;
    logic [2:0]        initial_leds_reg;
    logic [1:0]        shift_reg, shift_next;
    logic [2:0]        leds_reg, leds_next;
    logic [QIDX_W-1:0] head_reg, head_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              ack_reg, ack_next;
    logic [7:0]        pending_reg;
    logic              phase_reg, phase_next;
    result_t           res_reg, res_next;

    logic              res_ready;
    logic              fire;
    logic              release_item;
    logic              push_req;
    logic [7:0]        push_data;
    logic              rd_en;
    logic [7:0]        rd_data;
    logic              wr_en;
    logic [QIDX_W:0]   tail_sum;
    logic [QIDX_W-1:0] tail;
    logic [7:0]        ch;

    kst_keymap u_keymap (
        .code    (in_code_reg),
        .shifted (shift_reg != 2'b00),
        .caps    (leds_reg[2]),
        .ch      (ch)
    );

    kst_ram #(
        .WIDTH (8),
        .DEPTH (CMD_QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (tail),
        .wr_data (push_data),
        .rd_en   (rd_en),
        .rd_addr (head_reg),
        .rd_data (rd_data)
    );

    assign res_ready     = !res_reg.valid || m_axis_tready;
    assign fire          = in_valid_reg && res_ready;
    assign s_axis_tready = !in_valid_reg || release_item;

    always_comb
    begin
        tail_sum = (QIDX_W + 1)'(head_reg) + (QIDX_W + 1)'(count_reg);
        tail     = (tail_sum >= DEPTH_SUM) ? QIDX_W'(tail_sum - DEPTH_SUM) : QIDX_W'(tail_sum);
    end

    always_comb
    begin
        shift_next   = shift_reg;
        leds_next    = leds_reg;
        head_next    = head_reg;
        ack_next     = ack_reg;
        phase_next   = phase_reg;
        release_item = 1'b0;
        push_req     = 1'b0;
        push_data    = LED_CMD;
        rd_en        = 1'b0;
        res_next     = '{valid: 1'b0, kind: KIND_CHAR, src: SRC_DIRECT, value: 8'h00};

        if (fire)
        begin
            if (phase_reg)
            begin
                // second byte of an led command
                push_req     = 1'b1;
                push_data    = {5'b00000, leds_reg};
                phase_next   = 1'b0;
                release_item = 1'b1;
            end
            else
            begin
                case (in_cmd_reg)
                    CMD_POLL:
                    begin
                        release_item = 1'b1;
                        if ((count_reg != '0) && !ack_reg)
                        begin
                            rd_en     = 1'b1;
                            head_next = (head_reg == LAST_IDX) ? '0 : head_reg + 1'b1;
                            ack_next  = 1'b1;
                            res_next  = '{valid: 1'b1, kind: KIND_SEND, src: SRC_RAM,
                                          value: 8'h00};
                        end
                    end
                    CMD_SYNC:
                    begin
                        leds_next  = initial_leds_reg;
                        push_req   = 1'b1;
                        phase_next = 1'b1;
                    end
                    CMD_SCAN:
                    begin
                        release_item = 1'b1;
                        if (ch != 8'h00)
                        begin
                            res_next = '{valid: 1'b1, kind: KIND_CHAR, src: SRC_DIRECT,
                                         value: ch};
                        end
                        case (in_code_reg)
                            SC_TAB:
                            begin
                                res_next = '{valid: 1'b1, kind: KIND_FOCUS, src: SRC_DIRECT,
                                             value: 8'h00};
                            end
                            SC_LSHIFT_MAKE:  shift_next = shift_reg | 2'b01;
                            SC_RSHIFT_MAKE:  shift_next = shift_reg | 2'b10;
                            SC_LSHIFT_BREAK: shift_next = shift_reg & 2'b10;
                            SC_RSHIFT_BREAK: shift_next = shift_reg & 2'b01;
                            SC_CAPS, SC_NUM, SC_SCROLL:
                            begin
                                if (in_code_reg == SC_CAPS)
                                begin
                                    leds_next = leds_reg ^ LED_CAPS;
                                end
                                else if (in_code_reg == SC_NUM)
                                begin
                                    leds_next = leds_reg ^ LED_NUM;
                                end
                                else
                                begin
                                    leds_next = leds_reg ^ LED_SCROLL;
                                end
                                push_req     = 1'b1;
                                phase_next   = 1'b1;
                                release_item = 1'b0;
                            end
                            SC_ACK: ack_next = 1'b0;
                            SC_RESEND:
                            begin
                                if (ack_reg)
                                begin
                                    res_next = '{valid: 1'b1, kind: KIND_SEND,
                                                 src: SRC_PENDING, value: 8'h00};
                                end
                            end
                            default: ;
                        endcase
                    end
                    default: release_item = 1'b1;
                endcase
            end
        end
    end

    // a push and a pop never come from the same word
    always_comb
    begin
        wr_en      = push_req && (count_reg < DEPTH_CNT);
        count_next = count_reg;
        if (wr_en)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (rd_en)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg     <= 1'b0;
            initial_leds_reg <= 3'b000;
            shift_reg        <= 2'b00;
            leds_reg         <= 3'b000;
            head_reg         <= '0;
            count_reg        <= '0;
            ack_reg          <= 1'b0;
            pending_reg      <= 8'h00;
            phase_reg        <= 1'b0;
            res_reg          <= '{valid: 1'b0, kind: KIND_CHAR, src: SRC_DIRECT, value: 8'h00};
        end
        else
        begin
            if (cfg_wr_en)
            begin
                initial_leds_reg <= cfg_wr_data;
            end
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
            end
            shift_reg <= shift_next;
            leds_reg  <= leds_next;
            head_reg  <= head_next;
            count_reg <= count_next;
            ack_reg   <= ack_next;
            phase_reg <= phase_next;
            if (res_reg.valid && m_axis_tready && (res_reg.src == SRC_RAM))
            begin
                pending_reg <= rd_data;
            end
            if (res_ready)
            begin
                res_reg <= res_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready)
        begin
            in_cmd_reg  <= command_t'(s_axis_tuser);
            in_code_reg <= s_axis_tdata;
        end
    end

    always_comb
    begin
        case (res_reg.src)
            SRC_RAM:     m_axis_tdata = rd_data;
            SRC_PENDING: m_axis_tdata = pending_reg;
            default:     m_axis_tdata = res_reg.value;
        endcase
    end

    assign m_axis_tvalid = res_reg.valid;
    assign m_axis_tuser  = res_reg.kind;
    assign m_axis_tlast  = 1'b1;

endmodule

// File: src/kst_checker.sv
// port-level checks of the scan code translator, bound to the top level
module kst_checker
    import kst_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       s_axis_tvalid,
    input logic       s_axis_tready,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata,
    input logic [1:0] m_axis_tuser,
    input logic       m_axis_tlast
);

    // a stalled word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("output word changed while stalled");

    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tlast)
        else $error("single result word without last");

    a_focus_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser == KIND_FOCUS) |-> (m_axis_tdata == 8'h00))
        else $error("focus event with non-zero value");

    a_char_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser == KIND_CHAR) |-> (m_axis_tdata != 8'h00))
        else $error("character word with zero code");

    // with no word taken in and none shown over the window that the property looks back on, no word comes out
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid && !$past(s_axis_tvalid && s_axis_tready) && !$past(m_axis_tvalid, 1)
            && !$past(s_axis_tvalid && s_axis_tready, 2) && !$past(m_axis_tvalid, 2)
            && !$past(s_axis_tvalid && s_axis_tready, 3)
        |=> !m_axis_tvalid)
        else $error("output word without an input word");

endmodule

bind keyboard_scancode_translator kst_checker u_kst_checker (.*);
